FILE: hdl/bpa_pkg.sv
`timescale 1ns / 1ps
package bpa_pkg;

  localparam int MAX_ORDER     = 10;
  localparam int TABLE_ENTRIES = 4096;
  localparam int PAGE_BITS     = 32;
  localparam int ZONES         = 3;
  localparam int AW            = $clog2(TABLE_ENTRIES);
  localparam int ORDER_W       = $clog2(MAX_ORDER + 1);

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_REL   = 2'd2,
    MODE_BAD   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_NOMEM    = 2'd1,
    STS_NOTFOUND = 2'd2,
    STS_BAD      = 2'd3
  } status_t;

  // one block table entry
  typedef struct packed {
    logic                 valid;
    logic                 used;
    logic [1:0]           zone;
    logic [ORDER_W-1:0]   order;
    logic [PAGE_BITS-1:0] base;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // what a table sweep looks for
  typedef struct packed {
    logic [AW-1:0]        cur_idx;
    entry_t               cur;
    logic [1:0]           zone;
    logic [ORDER_W-1:0]   ord;
    logic [PAGE_BITS-1:0] page;
  } scan_key_t;

  // what a table sweep found
  typedef struct packed {
    logic                 sp_f;
    logic [AW-1:0]        sp_idx;
    logic [AW:0]          sp_cnt;
    logic                 pk_f;
    logic [AW-1:0]        pk_idx;
    logic [ORDER_W-1:0]   pk_order;
    logic [PAGE_BITS-1:0] pk_base;
    logic                 sc_f;
    logic [AW-1:0]        sc_idx;
    logic [PAGE_BITS-1:0] sc_base;
    logic                 pr_f;
    logic [AW-1:0]        pr_idx;
    logic [PAGE_BITS-1:0] pr_base;
    logic                 hit_f;
    logic [AW-1:0]        hit_idx;
    logic [1:0]           hit_zone;
    logic [ORDER_W-1:0]   hit_order;
  } scan_res_t;

endpackage

FILE: hdl/bpa_ram.sv
`timescale 1ns / 1ps
module bpa_ram #(
  parameter int AW_P = 12,
  parameter int DW_P = 40
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW_P-1:0] waddr,
  input  logic [DW_P-1:0] wdata,
  input  logic            re,
  input  logic [AW_P-1:0] raddr,
  output logic [DW_P-1:0] rdata
);

  logic [DW_P-1:0] mem [2**AW_P];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

FILE: hdl/bpa_scan.sv
`timescale 1ns / 1ps
module bpa_scan import bpa_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  scan_key_t     key,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  entry_t        rd_data,
  output logic          done,
  output scan_res_t     res
);

  logic [AW:0]   cnt_r;
  logic          run_r;
  logic          chk_v_r;
  logic [AW-1:0] chk_idx_r;
  scan_res_t     res_r;
  scan_res_t     res_nxt;
  logic          issue;
  logic          in_list;
  logic [PAGE_BITS+AW-1:0] kj, kc;

  assign issue   = run_r && (cnt_r < (AW+1)'(TABLE_ENTRIES));
  assign rd_en   = issue;
  assign rd_addr = cnt_r[AW-1:0];
  assign done    = run_r && !issue && !chk_v_r;
  assign res     = res_r;

  // fold one entry into the running results
  always_comb begin
    res_nxt = res_r;
    kj      = {rd_data.base, chk_idx_r};
    kc      = {key.cur.base, key.cur_idx};
    in_list = rd_data.valid && !rd_data.used && rd_data.zone == key.cur.zone &&
              rd_data.order == key.cur.order;
    // empty slots
    if (!rd_data.valid) begin
      res_nxt.sp_cnt = res_r.sp_cnt + 1'b1;
      if (!res_r.sp_f) begin
        res_nxt.sp_f   = 1'b1;
        res_nxt.sp_idx = chk_idx_r;
      end
    end
    // neighbors of the current block in its free list
    if (in_list && kj > kc && (!res_r.sc_f || kj < {res_r.sc_base, res_r.sc_idx})) begin
      res_nxt.sc_f    = 1'b1;
      res_nxt.sc_idx  = chk_idx_r;
      res_nxt.sc_base = rd_data.base;
    end
    if (in_list && kj < kc && (!res_r.pr_f || kj > {res_r.pr_base, res_r.pr_idx})) begin
      res_nxt.pr_f    = 1'b1;
      res_nxt.pr_idx  = chk_idx_r;
      res_nxt.pr_base = rd_data.base;
    end
    // smallest sufficient order, then lowest base, then lowest index
    if (rd_data.valid && !rd_data.used && rd_data.zone == key.zone &&
        rd_data.order >= key.ord &&
        (!res_r.pk_f || {rd_data.order, rd_data.base, chk_idx_r} <
                        {res_r.pk_order, res_r.pk_base, res_r.pk_idx})) begin
      res_nxt.pk_f     = 1'b1;
      res_nxt.pk_idx   = chk_idx_r;
      res_nxt.pk_order = rd_data.order;
      res_nxt.pk_base  = rd_data.base;
    end
    // first allocated block at the release base
    if (rd_data.valid && rd_data.used && rd_data.base == key.page && !res_r.hit_f) begin
      res_nxt.hit_f     = 1'b1;
      res_nxt.hit_idx   = chk_idx_r;
      res_nxt.hit_zone  = rd_data.zone;
      res_nxt.hit_order = rd_data.order;
    end
  end

  // address counter and check stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      chk_v_r <= 1'b0;
      cnt_r   <= '0;
    end else if (start) begin
      run_r   <= 1'b1;
      chk_v_r <= 1'b0;
      cnt_r   <= '0;
      res_r   <= '0;
    end else begin
      chk_v_r   <= issue;
      chk_idx_r <= cnt_r[AW-1:0];
      if (issue) cnt_r <= cnt_r + 1'b1;
      if (chk_v_r) res_r <= res_nxt;
      if (done) run_r <= 1'b0;
    end
  end

endmodule

FILE: hdl/bpa_ctrl.sv
`timescale 1ns / 1ps
module bpa_ctrl import bpa_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [1:0]    in_mode,
  input  logic [31:0]   in_page,
  input  logic [3:0]    in_order,
  input  logic [1:0]    in_zone,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [1:0]    out_status,
  output logic [31:0]   out_page,
  output logic [1:0]    out_served,
  output logic [31:0]   out_free,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output entry_t        wr_data,
  output logic          scan_go,
  output scan_key_t     key,
  input  logic          scan_done,
  input  scan_res_t     res
);

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_WAIT, ST_ADD_W, ST_ZSEL, ST_TAKE, ST_SPLIT, ST_SPLIT_W,
    ST_REL_W, ST_SET, ST_SET_DEC, ST_SET_W2, ST_RET, ST_OUT
  } state_t;

  typedef enum logic [1:0] { RET_ADD, RET_REL, RET_SPLIT } ret_t;

  state_t               state_r, aft_r;
  ret_t                 ret_r;
  logic [AW-1:0]        clr_r;
  logic [1:0]           zi_r, rel_zone_r;
  logic [ORDER_W-1:0]   ord_r, k_r, rel_order_r;
  logic [PAGE_BITS-1:0] page_r, got_r, off_r;
  logic                 fall_r;
  logic [AW-1:0]        cur_idx_r, w2_idx_r;
  entry_t               cur_r, w2_ent_r;
  logic [31:0]          zfree_r [ZONES];
  logic [31:0]          all_free_r;
  logic [1:0]           res_status_r, res_served_r;
  logic [31:0]          res_page_r;
  logic                 out_v_r;
  logic [1:0]           o_status_r, o_served_r;
  logic [31:0]          o_page_r, o_free_r;

  logic                 accept;
  logic [1:0]           zin;
  logic                 take_ok, sm_sc, sm_pr;
  logic [PAGE_BITS:0]   size;
  logic [31:0]          need;
  entry_t               split_ent;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign zin        = (in_zone == 2'd3) ? 2'd2 : in_zone;
  assign out_tvalid = out_v_r;
  assign out_status = o_status_r;
  assign out_page   = o_page_r;
  assign out_served = o_served_r;
  assign out_free   = o_free_r;
  assign key        = '{cur_idx: cur_idx_r, cur: cur_r, zone: zi_r, ord: ord_r, page: page_r};

  // decisions on the sweep results
  always_comb begin
    need    = 32'(1) << ord_r;
    size    = (PAGE_BITS+1)'(1) << cur_r.order;
    take_ok = res.pk_f && !(res.pk_order > ord_r &&
              res.sp_cnt < (AW+1)'(res.pk_order - ord_r));
    sm_sc   = res.sc_f && ({1'b0, cur_r.base} + size == {1'b0, res.sc_base});
    sm_pr   = res.pr_f && ({1'b0, res.pr_base} + size == {1'b0, cur_r.base});
    split_ent = '{valid: 1'b1, used: 1'b0, zone: zi_r, order: k_r - 1'b1,
                  base: got_r + off_r};
  end

  // table write port and sweep start
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    scan_go = 1'b0;
    unique case (state_r)
      ST_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
      end
      ST_IDLE: begin
        scan_go = accept && ((mode_t'(in_mode) == MODE_ADD &&
                  in_order <= 4'(MAX_ORDER)) || mode_t'(in_mode) == MODE_REL);
      end
      ST_ADD_W: begin
        wr_en   = res.sp_f;
        wr_addr = res.sp_idx;
        wr_data = '{valid: 1'b1, used: 1'b0, zone: zi_r, order: ord_r, base: page_r};
      end
      ST_ZSEL: begin
        scan_go = fall_r || zfree_r[zi_r] >= need;
      end
      ST_TAKE: begin
        wr_en   = take_ok;
        wr_addr = res.pk_idx;
        wr_data = '{valid: 1'b1, used: 1'b1, zone: zi_r, order: ord_r, base: res.pk_base};
      end
      ST_SPLIT: begin
        scan_go = (k_r > ord_r);
      end
      ST_SPLIT_W: begin
        wr_en   = res.sp_f;
        wr_addr = res.sp_idx;
        wr_data = split_ent;
      end
      ST_REL_W: begin
        wr_en   = res.hit_f;
        wr_addr = res.hit_idx;
        wr_data = '{valid: 1'b1, used: 1'b0, zone: res.hit_zone, order: res.hit_order,
                    base: page_r};
      end
      ST_SET: begin
        scan_go = (cur_r.order < ORDER_W'(MAX_ORDER));
      end
      ST_SET_DEC: begin
        wr_en   = sm_sc || sm_pr;
        wr_addr = sm_sc ? res.sc_idx : cur_idx_r;
      end
      ST_SET_W2: begin
        wr_en   = 1'b1;
        wr_addr = w2_idx_r;
        wr_data = w2_ent_r;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      clr_r      <= '0;
      out_v_r    <= 1'b0;
      all_free_r <= '0;
      for (int z = 0; z < ZONES; z++) zfree_r[z] <= '0;
    end else begin
      if (out_v_r && out_tready && state_r != ST_OUT) out_v_r <= 1'b0;
      unique case (state_r)
        ST_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (&clr_r) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            page_r       <= PAGE_BITS'(in_page);
            ord_r        <= ORDER_W'(in_order);
            zi_r         <= zin;
            fall_r       <= 1'b0;
            res_page_r   <= '0;
            res_served_r <= '0;
            cur_idx_r    <= '0;
            cur_r        <= '0;
            res_status_r <= STS_OK;
            if (mode_t'(in_mode) == MODE_BAD ||
                (mode_t'(in_mode) != MODE_REL && in_order > 4'(MAX_ORDER))) begin
              res_status_r <= STS_BAD;
              state_r      <= ST_OUT;
            end else if (mode_t'(in_mode) == MODE_ALLOC) begin
              state_r <= ST_ZSEL;
            end else begin
              aft_r   <= (mode_t'(in_mode) == MODE_ADD) ? ST_ADD_W : ST_REL_W;
              state_r <= ST_WAIT;
            end
          end
        end
        ST_WAIT: begin
          if (scan_done) state_r <= aft_r;
        end
        ST_ADD_W: begin
          if (!res.sp_f) begin
            res_status_r <= STS_BAD;
            state_r      <= ST_OUT;
          end else begin
            cur_idx_r <= res.sp_idx;
            cur_r     <= '{valid: 1'b1, used: 1'b0, zone: zi_r, order: ord_r, base: page_r};
            ret_r     <= RET_ADD;
            state_r   <= ST_SET;
          end
        end
        // fall back through lower zones
        ST_ZSEL: begin
          if (scan_go) begin
            fall_r  <= 1'b1;
            aft_r   <= ST_TAKE;
            state_r <= ST_WAIT;
          end else if (zi_r == 2'd0) begin
            res_status_r <= STS_NOMEM;
            state_r      <= ST_OUT;
          end else begin
            zi_r <= zi_r - 1'b1;
          end
        end
        ST_TAKE: begin
          if (take_ok) begin
            got_r   <= res.pk_base;
            k_r     <= res.pk_order;
            off_r   <= PAGE_BITS'(need);
            state_r <= ST_SPLIT;
          end else if (zi_r == 2'd0) begin
            res_status_r <= STS_NOMEM;
            state_r      <= ST_OUT;
          end else begin
            zi_r    <= zi_r - 1'b1;
            state_r <= ST_ZSEL;
          end
        end
        // hand back the remainder one piece at a time
        ST_SPLIT: begin
          if (scan_go) begin
            aft_r   <= ST_SPLIT_W;
            state_r <= ST_WAIT;
          end else begin
            zfree_r[zi_r] <= zfree_r[zi_r] - need;
            all_free_r    <= all_free_r - need;
            res_page_r    <= got_r;
            res_served_r  <= zi_r;
            state_r       <= ST_OUT;
          end
        end
        ST_SPLIT_W: begin
          if (!res.sp_f) begin
            k_r     <= ord_r;
            state_r <= ST_SPLIT;
          end else begin
            cur_idx_r <= res.sp_idx;
            cur_r     <= split_ent;
            off_r     <= off_r + (PAGE_BITS'(1) << (k_r - 1'b1));
            k_r       <= k_r - 1'b1;
            ret_r     <= RET_SPLIT;
            state_r   <= ST_SET;
          end
        end
        ST_REL_W: begin
          if (!res.hit_f) begin
            res_status_r <= STS_NOTFOUND;
            state_r      <= ST_OUT;
          end else begin
            cur_idx_r   <= res.hit_idx;
            cur_r       <= '{valid: 1'b1, used: 1'b0, zone: res.hit_zone,
                             order: res.hit_order, base: page_r};
            rel_zone_r  <= res.hit_zone;
            rel_order_r <= res.hit_order;
            ret_r       <= RET_REL;
            state_r     <= ST_SET;
          end
        end
        // merge with a buddy until nothing fits
        ST_SET: begin
          if (scan_go) begin
            aft_r   <= ST_SET_DEC;
            state_r <= ST_WAIT;
          end else begin
            state_r <= ST_RET;
          end
        end
        ST_SET_DEC: begin
          if (sm_sc) begin
            cur_r.order <= cur_r.order + 1'b1;
            w2_idx_r    <= cur_idx_r;
            w2_ent_r    <= '{valid: 1'b1, used: 1'b0, zone: cur_r.zone,
                             order: cur_r.order + 1'b1, base: cur_r.base};
            state_r     <= ST_SET_W2;
          end else if (sm_pr) begin
            cur_idx_r   <= res.pr_idx;
            cur_r       <= '{valid: 1'b1, used: 1'b0, zone: cur_r.zone,
                             order: cur_r.order + 1'b1, base: res.pr_base};
            w2_idx_r    <= res.pr_idx;
            w2_ent_r    <= '{valid: 1'b1, used: 1'b0, zone: cur_r.zone,
                             order: cur_r.order + 1'b1, base: res.pr_base};
            state_r     <= ST_SET_W2;
          end else begin
            state_r <= ST_RET;
          end
        end
        ST_SET_W2: begin
          state_r <= ST_SET;
        end
        ST_RET: begin
          unique case (ret_r)
            RET_ADD: begin
              zfree_r[zi_r] <= zfree_r[zi_r] + need;
              all_free_r    <= all_free_r + need;
              state_r       <= ST_OUT;
            end
            RET_REL: begin
              zfree_r[rel_zone_r] <= zfree_r[rel_zone_r] + (32'(1) << rel_order_r);
              all_free_r          <= all_free_r + (32'(1) << rel_order_r);
              res_served_r        <= rel_zone_r;
              state_r             <= ST_OUT;
            end
            default: state_r <= ST_SPLIT;
          endcase
        end
        ST_OUT: begin
          if (!out_v_r || out_tready) begin
            out_v_r    <= 1'b1;
            o_status_r <= res_status_r;
            o_page_r   <= res_page_r;
            o_served_r <= res_served_r;
            o_free_r   <= all_free_r;
            state_r    <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/buddy_page_allocator_core.sv
`timescale 1ns / 1ps
// Buddy page allocator over three zones (dma, dma32, normal).
// Input words on in_*: add a free block, allocate by order, or release by base.
// Each input word yields exactly one result word on out_*.
// Work is sequential: one word at a time. Every step that needs the block
// table sweeps all 4096 entries through the registered table memory. An add
// or release costs one sweep to find its entry, one per merge step and a
// last one that finds no buddy (skipped once the block reaches the top
// order); an allocate costs one sweep per zone tried, one per split piece
// and the merge sweeps of each piece; a bad mode or order needs no sweep.
// After reset the table is cleared one entry per cycle with in_tready low;
// counters start at zero.
// A finished result sits in the output register; the block then takes the
// next input word and holds its own next result until out_tready frees the
// output register.
module buddy_page_allocator_core import bpa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // mode[1:0], block_page[33:2], block_order[37:34], zone[39:38]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // status[1:0], page[33:2], served_zone[35:34],
                                  // free_cnt[67:36], zero[71:68]
);

  logic          wr_en, rd_en, scan_go, scan_done;
  logic [AW-1:0] wr_addr, rd_addr;
  entry_t        wr_data, rd_data;
  scan_key_t     key;
  scan_res_t     res;
  logic [1:0]    o_status, o_served;
  logic [31:0]   o_page, o_free;

  bpa_ram #(.AW_P(AW), .DW_P(ENTRY_W)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  bpa_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scan_go),
    .key     (key),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .done    (scan_done),
    .res     (res)
  );

  bpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (in_tdata[1:0]),
    .in_page    (in_tdata[33:2]),
    .in_order   (in_tdata[37:34]),
    .in_zone    (in_tdata[39:38]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (o_status),
    .out_page   (o_page),
    .out_served (o_served),
    .out_free   (o_free),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .scan_go    (scan_go),
    .key        (key),
    .scan_done  (scan_done),
    .res        (res)
  );

  assign out_tdata = {4'b0, o_free, o_served, o_page, o_status};

endmodule

FILE: hdl/bpa_checker.sv
`timescale 1ns / 1ps
module bpa_checker import bpa_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  // a stalled word stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word dropped or changed while stalled");

  // table clear pass blocks input right after reset
  a_clr: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !in_tready)
    else $error("input taken during table clear");

  // one word in flight at a time
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken while busy");

  // page is zero unless the status is ok
  a_page: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != STS_OK |-> out_tdata[33:2] == 32'd0)
    else $error("page set on a failed word");

endmodule

bind buddy_page_allocator_core bpa_checker u_bpa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import bpa_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] page;
    logic [1:0]  zone;
    logic [31:0] free;
  } alloc_result_t;

  // buddy allocator shadow plus queue of expected result words
  class alloc_scoreboard;
    bit          ent_valid[TABLE_ENTRIES];
    bit          ent_used[TABLE_ENTRIES];
    bit [1:0]    ent_zone[TABLE_ENTRIES];
    bit [3:0]    ent_order[TABLE_ENTRIES];
    bit [31:0]   ent_base[TABLE_ENTRIES];
    bit [31:0]   zone_free[3];
    bit [31:0]   zone_total[3];
    bit [31:0]   free_total;
    bit [31:0]   page_total;
    alloc_result_t pending_q[$];
    int          errors;
    int          checked;
    int          sts_seen[4];

    function bit earlier(int a, int b);
      return ent_base[a] < ent_base[b] || (ent_base[a] == ent_base[b] && a < b);
    endfunction

    function bit on_list(int j, bit [1:0] z, bit [3:0] o);
      return ent_valid[j] && !ent_used[j] && ent_zone[j] == z && ent_order[j] == o;
    endfunction

    function int first_free(bit [1:0] z, bit [3:0] o);
      int best;
      best = -1;
      for (int j = 0; j < TABLE_ENTRIES; j++)
        if (on_list(j, z, o) && (best < 0 || earlier(j, best))) best = j;
      return best;
    endfunction

    function int next_on_list(int i);
      int best;
      best = -1;
      for (int j = 0; j < TABLE_ENTRIES; j++)
        if (j != i && on_list(j, ent_zone[i], ent_order[i]) && earlier(i, j) &&
            (best < 0 || earlier(j, best))) best = j;
      return best;
    endfunction

    function int prev_on_list(int i);
      int best;
      best = -1;
      for (int j = 0; j < TABLE_ENTRIES; j++)
        if (j != i && on_list(j, ent_zone[i], ent_order[i]) && earlier(j, i) &&
            (best < 0 || earlier(best, j))) best = j;
      return best;
    endfunction

    function int empty_slot();
      for (int j = 0; j < TABLE_ENTRIES; j++)
        if (!ent_valid[j]) return j;
      return -1;
    endfunction

    function int empty_count();
      int n;
      n = 0;
      for (int j = 0; j < TABLE_ENTRIES; j++)
        if (!ent_valid[j]) n++;
      return n;
    endfunction

    // merge a free block with contiguous buddies, end computed without wrap
    function void merge_up(int i);
      longint unsigned size;
      int n, p;
      bit busy;
      busy = 1;
      while (busy && ent_order[i] < MAX_ORDER) begin
        size = 64'd1 << ent_order[i];
        n = next_on_list(i);
        p = prev_on_list(i);
        if (n >= 0 && 64'(ent_base[i]) + size == 64'(ent_base[n])) begin
          ent_valid[n] = 0;
          ent_order[i]++;
        end else if (p >= 0 && 64'(ent_base[p]) + size == 64'(ent_base[i])) begin
          ent_valid[i] = 0;
          ent_order[p]++;
          i = p;
        end else begin
          busy = 0;
        end
      end
    endfunction

    // take a block from one zone, splitting the remainder after it
    function int take_from_zone(bit [1:0] z, int o);
      int pick, ro, s;
      bit [31:0] off;
      pick = -1;
      for (ro = o; ro <= MAX_ORDER; ro++) begin
        pick = first_free(z, ro);
        if (pick >= 0) break;
      end
      if (pick < 0) return -1;
      if (ro > o) begin
        if (empty_count() < ro - o) return -1;
        ent_used[pick] = 1;
        ent_order[pick] = 4'(o);
        off = 32'd1 << o;
        for (int k = ro; k > o; k--) begin
          s = empty_slot();
          if (s < 0) break;
          ent_valid[s] = 1;
          ent_used[s] = 0;
          ent_zone[s] = z;
          ent_order[s] = 4'(k - 1);
          ent_base[s] = ent_base[pick] + off;
          off += 32'd1 << (k - 1);
          merge_up(s);
        end
      end else begin
        ent_used[pick] = 1;
      end
      zone_free[z] -= 32'd1 << o;
      free_total -= 32'd1 << o;
      return pick;
    endfunction

    function alloc_result_t note_input(mode_t m, bit [31:0] pg, bit [3:0] o, bit [1:0] zsel);
      alloc_result_t r;
      int s, idx, blk, hit;
      bit [1:0] zn;
      bit [31:0] need;
      r = '0;
      r.status = STS_OK;
      zn = (zsel > 2) ? 2'd2 : zsel;
      case (m)
        MODE_ADD: begin
          s = (o > MAX_ORDER) ? -1 : empty_slot();
          if (s < 0) begin
            r.status = STS_BAD;
          end else begin
            ent_valid[s] = 1;
            ent_used[s] = 0;
            ent_zone[s] = zn;
            ent_order[s] = o;
            ent_base[s] = pg;
            merge_up(s);
            zone_total[zn] += 32'd1 << o;
            zone_free[zn] += 32'd1 << o;
            page_total += 32'd1 << o;
            free_total += 32'd1 << o;
          end
        end
        MODE_ALLOC: begin
          if (o > MAX_ORDER) begin
            r.status = STS_BAD;
          end else begin
            need = 32'd1 << o;
            idx = zn;
            blk = -1;
            while (idx >= 0 && zone_free[idx] < need) idx--;
            while (idx >= 0) begin
              blk = take_from_zone(2'(idx), o);
              if (blk >= 0) break;
              idx--;
            end
            if (blk < 0) begin
              r.status = STS_NOMEM;
            end else begin
              r.page = ent_base[blk];
              r.zone = 2'(idx);
            end
          end
        end
        MODE_REL: begin
          hit = -1;
          for (int j = 0; j < TABLE_ENTRIES; j++)
            if (hit < 0 && ent_valid[j] && ent_used[j] && ent_base[j] == pg) hit = j;
          if (hit < 0) begin
            r.status = STS_NOTFOUND;
          end else begin
            r.zone = ent_zone[hit];
            need = 32'd1 << ent_order[hit];
            ent_used[hit] = 0;
            merge_up(hit);
            zone_free[r.zone] += need;
            free_total += need;
          end
        end
        default: r.status = STS_BAD;
      endcase
      r.free = free_total;
      sts_seen[r.status]++;
      pending_q.push_back(r);
      return r;
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_result(logic [71:0] d);
      alloc_result_t e;
      checked++;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %h", d));
      end else begin
        e = pending_q.pop_front();
        if (d[1:0] !== e.status)
          report_mismatch($sformatf("status %0d, want %0d", d[1:0], e.status));
        if (d[33:2] !== e.page)
          report_mismatch($sformatf("page %h, want %h", d[33:2], e.page));
        if (d[35:34] !== e.zone)
          report_mismatch($sformatf("served zone %0d, want %0d", d[35:34], e.zone));
        if (d[67:36] !== e.free)
          report_mismatch($sformatf("free pages %0d, want %0d", d[67:36], e.free));
        if (d[71:68] !== 4'd0)
          report_mismatch($sformatf("pad bits %h not zero", d[71:68]));
      end
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [71:0] out_tdata;

  alloc_scoreboard sb = new();
  bit [31:0] live_q[$];
  logic      calm = 0;
  logic      hold_req = 0;
  int        hold_cnt = 0;
  bit        hold_done = 0;

  buddy_page_allocator_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (10) #1_000_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: random stalls, one long hold-off
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1;
      hold_cnt = 40000;
    end
    if (hold_cnt > 0) hold_cnt--;
    if (!rst_n || hold_cnt > 0) out_tready <= 0;
    else if (calm) out_tready <= 1;
    else out_tready <= ($urandom_range(0, 99) >= 7);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // offer one word and wait until it is taken
  task send_word(mode_t m, bit [31:0] pg, bit [3:0] o, bit [1:0] z);
    alloc_result_t r;
    if (!calm && $urandom_range(0, 99) < 7) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {z, o, pg, m};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = sb.note_input(m, pg, o, z);
    if (m == MODE_ALLOC && r.status == STS_OK) live_q.push_back(r.page);
    if (m == MODE_REL && r.status == STS_OK)
      foreach (live_q[i])
        if (live_q[i] == pg) begin
          live_q.delete(i);
          break;
        end
  endtask

  initial begin
    int        pick, o, z;
    bit [31:0] pg;
    repeat (4) @(posedge clk);
    rst_n <= 1;

    // directed: wrap on split, merges, fallback, bad codes
    send_word(MODE_ADD, 32'hFFFF_FFFC, 3, 0);
    send_word(MODE_ALLOC, 0, 0, 0);
    send_word(MODE_REL, 32'hFFFF_FFFC, 0, 0);
    send_word(MODE_ADD, 32'h0000_1000, 0, 0);
    send_word(MODE_ADD, 32'h0000_1001, 0, 0);
    send_word(MODE_ADD, 32'h0010_0000, 10, 1);
    send_word(MODE_ADD, 32'h0002_0000, 4, 3);
    send_word(MODE_ADD, 32'h0003_0000, 11, 0);
    send_word(MODE_ADD, 32'h0003_0000, 15, 2);
    send_word(MODE_BAD, 32'hFFFF_FFFF, 15, 3);
    send_word(MODE_ALLOC, 0, 12, 1);
    send_word(MODE_ALLOC, 0, 2, 2);
    send_word(MODE_ALLOC, 0, 0, 3);
    send_word(MODE_ALLOC, 0, 10, 2);
    send_word(MODE_ALLOC, 0, 5, 0);
    send_word(MODE_REL, 32'hDEAD_BEEF, 0, 0);
    send_word(MODE_REL, 32'h0002_0000, 0, 2);
    send_word(MODE_REL, 32'h0010_0000, 0, 1);
    send_word(MODE_ADD, 32'hFFFF_FFFF, 0, 1);
    send_word(MODE_ADD, 32'h0000_0000, 0, 1);
    send_word(MODE_ALLOC, 0, 0, 1);

    // random: mostly well-formed add / allocate / release mix
    for (int n = 0; n < 730; n++) begin
      calm <= (n >= 400 && n < 480);
      if (n == 150) hold_req <= 1;
      if (n == 300) begin
        in_tvalid <= 0;
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
      end
      o = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 4) : $urandom_range(5, 10);
      z = $urandom_range(0, 3);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        pg = ((z + 1) << 20) + ($urandom_range(0, 255) << 10) +
             ($urandom_range(0, (1 << (10 - o)) - 1) << o);
        send_word(MODE_ADD, pg, 4'(o), 2'(z));
      end else if (pick < 65) begin
        send_word(MODE_ALLOC, $urandom, 4'(o), 2'(z));
      end else if (pick < 90 && live_q.size() > 0) begin
        send_word(MODE_REL, live_q[$urandom_range(0, live_q.size() - 1)], 4'($urandom),
                  2'(z));
      end else begin
        send_word(mode_t'($urandom_range(0, 3)), $urandom, 4'($urandom_range(0, 15)),
                  2'($urandom_range(0, 3)));
      end
    end
    in_tvalid <= 0;

    // drain, then a short settle
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d result words: ok %0d, out of memory %0d, not found %0d, bad %0d",
             sb.checked, sb.sts_seen[STS_OK], sb.sts_seen[STS_NOMEM],
             sb.sts_seen[STS_NOTFOUND], sb.sts_seen[STS_BAD]);
    $display("adds, splits with wrap, merges, zone fallback, long output stall and drain");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
